// ----- hdl/swm_pkg.sv -----
// Shared constants, types and codes for the sliding window maximum block.
package swm_pkg;

  localparam int WINDOW_MAX = 64;
  localparam int DATA_W     = 32;
  localparam int CFG_W      = 7;
  localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
  localparam int IDX_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int LEN_W      = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int GRP_SIZE   = 8;
  localparam int N_GRP      = (WINDOW_MAX + GRP_SIZE - 1) / GRP_SIZE;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam logic [CFG_W-1:0] WIN_RESET = CFG_W'(1);

  typedef enum logic [0:0] {
    REG_WINDOW_SIZE = 1'b0
  } reg_idx_t;

  typedef logic signed [DATA_W-1:0] sample_t;

  typedef struct packed {
    logic                  emit;
    logic [WINDOW_MAX-1:0] pick;
  } swm_step_t;

endpackage

// ----- hdl/swm_in_if.sv -----
// Sample request channel: valid/ready handshake with sample and first flag.
interface swm_in_if
  import swm_pkg::*;
  ;
  logic    valid;
  logic    ready;
  sample_t sample;
  logic    first;

  modport source (output valid, output sample, output first, input ready);
  modport sink   (input valid, input sample, input first, output ready);
endinterface

// ----- hdl/swm_out_if.sv -----
// Result request channel: valid/ready handshake with the window maximum.
interface swm_out_if
  import swm_pkg::*;
  ;
  logic    valid;
  logic    ready;
  sample_t window_max;

  modport source (output valid, output window_max, input ready);
  modport sink   (input valid, input window_max, output ready);
endinterface

// ----- hdl/swm_cell.sv -----
// One chain cell: running maximum of the last samples, handed to the next cell.
module swm_cell
  import swm_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step,
  input  sample_t sample,
  input  sample_t prev,
  input  logic    pick,
  output sample_t val,
  output sample_t pick_val
);

  sample_t val_r;
  sample_t val_nxt;
  logic    pick_r;

  assign val_nxt  = (prev > sample) ? prev : sample;
  assign val      = val_r;
  assign pick_val = pick_r ? val_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pick_r <= 1'b0;
    end else if (step) begin
      pick_r <= pick;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      val_r <= val_nxt;
    end
  end

endmodule

// ----- hdl/swm_ctrl.sv -----
// Live window length, sample count and result selection for the cell chain.
module swm_ctrl
  import swm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic             first,
  input  logic [CFG_W-1:0] win_cfg,
  output swm_step_t        step_o
);

  logic [CNT_W-1:0] len_r;
  logic [CNT_W-1:0] len_nxt;
  logic [CNT_W-1:0] seen_r;
  logic [CNT_W-1:0] seen_nxt;
  logic [CNT_W-1:0] base_len;
  logic [CNT_W-1:0] base_seen;
  logic [LEN_W-1:0] cfg_ext;
  logic [LEN_W-1:0] eff_w;
  logic [LEN_W-1:0] len_inc;
  logic [IDX_W-1:0] pick_idx;

  always_comb begin
    cfg_ext = LEN_W'(win_cfg);
    if (cfg_ext == '0) begin
      eff_w = LEN_W'(1);
    end else if (cfg_ext > LEN_W'(WINDOW_MAX)) begin
      eff_w = LEN_W'(WINDOW_MAX);
    end else begin
      eff_w = cfg_ext;
    end
  end

  // live length grows by one per sample, never past the current window
  always_comb begin
    base_len  = first ? '0 : len_r;
    base_seen = first ? '0 : seen_r;
    len_inc   = LEN_W'(base_len) + LEN_W'(1);
    len_nxt   = (len_inc > eff_w) ? CNT_W'(eff_w) : CNT_W'(len_inc);
    seen_nxt  = (base_seen < CNT_W'(WINDOW_MAX)) ? base_seen + CNT_W'(1) : base_seen;
    pick_idx  = IDX_W'(len_nxt - CNT_W'(1));
  end

  assign step_o.emit = (LEN_W'(seen_nxt) >= eff_w);

  for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_pick
    assign step_o.pick[k] = (pick_idx == IDX_W'(k));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= '0;
      seen_r <= '0;
    end else if (step) begin
      len_r  <= len_nxt;
      seen_r <= seen_nxt;
    end
  end

  a_len_le_seen: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= seen_r)
    else $error("live length exceeds samples seen");

  a_seen_sat: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r <= CNT_W'(WINDOW_MAX))
    else $error("sample count past saturation");

  a_pick_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(step_o.pick))
    else $error("cell select not one-hot");

endmodule

// ----- hdl/swm_or_tree.sv -----
// Two-stage registered OR tree gathering the selected cell value, with output register.
module swm_or_tree
  import swm_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    en,
  input  logic    v_in,
  input  sample_t leaf [WINDOW_MAX],
  output sample_t max_o,
  output logic    vld_o
);

  sample_t grp_r   [N_GRP];
  sample_t grp_nxt [N_GRP];
  sample_t max_r;
  sample_t max_nxt;
  logic    va_r;
  logic    vb_r;
  logic    vld_r;

  always_comb begin
    for (int g = 0; g < N_GRP; g++) begin
      grp_nxt[g] = '0;
      for (int j = 0; j < GRP_SIZE; j++) begin
        if (g * GRP_SIZE + j < WINDOW_MAX) begin
          grp_nxt[g] = grp_nxt[g] | leaf[g * GRP_SIZE + j];
        end
      end
    end
  end

  always_comb begin
    max_nxt = '0;
    for (int g = 0; g < N_GRP; g++) begin
      max_nxt = max_nxt | grp_r[g];
    end
  end

  // va_r tracks the cell stage, vb_r the group stage, vld_r the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r  <= 1'b0;
      vb_r  <= 1'b0;
      vld_r <= 1'b0;
    end else if (en) begin
      va_r  <= v_in;
      vb_r  <= va_r;
      vld_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      grp_r <= grp_nxt;
      max_r <= max_nxt;
    end
  end

  assign max_o = max_r;
  assign vld_o = vld_r;

  a_vld_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(vld_r) |-> $past(vb_r))
    else $error("result valid without a gathered request");

endmodule

// ----- hdl/sliding_window_maximum.sv -----
// Sliding window maximum top level: APB window register, cell chain, gather tree.
// A sample's result is registered in the cells, then in the group register, then in the output register.
// Throughput: one sample per cycle while the output is not stalled; every cell updates in parallel on each request.
// The WINDOW_MAX max cells form one register level; with the two-stage OR gather they set the pipeline depth.
// Reset (synchronous, rst_n low): window_size = 1, sequence empty, no result pending.
// Cell values are not reset; they are read only once covered by samples of the sequence.
module sliding_window_maximum
  import swm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  swm_in_if.sink                in_ch,
  swm_out_if.source             out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [CFG_W-1:0] win_r;
  logic             win_sel;
  logic             en;
  logic             accept;
  logic             out_vld;
  swm_step_t        step;
  sample_t          cell_val  [WINDOW_MAX];
  sample_t          cell_prev [WINDOW_MAX];
  sample_t          pick_val  [WINDOW_MAX];

  assign win_sel = (paddr[APB_ADDR_W-1:2] == REG_WINDOW_SIZE) && (paddr[1:0] == 2'b00);
  assign pready  = 1'b1;
  assign prdata  = win_sel ? APB_DATA_W'(win_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= WIN_RESET;
    end else if (psel && penable && pwrite && win_sel) begin
      win_r <= pwdata[CFG_W-1:0];
    end
  end

  assign en          = !out_vld || out_ch.ready;
  assign in_ch.ready = en;
  assign accept      = in_ch.valid && en;

  swm_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (accept),
    .first   (in_ch.first),
    .win_cfg (win_r),
    .step_o  (step)
  );

  for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign cell_prev[k] = in_ch.sample;
    end else begin : g_link
      assign cell_prev[k] = cell_val[k-1];
    end

    swm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .step     (accept),
      .sample   (in_ch.sample),
      .prev     (cell_prev[k]),
      .pick     (step.pick[k]),
      .val      (cell_val[k]),
      .pick_val (pick_val[k])
    );
  end

  swm_or_tree u_tree (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .v_in  (accept && step.emit),
    .leaf  (pick_val),
    .max_o (out_ch.window_max),
    .vld_o (out_vld)
  );

  assign out_ch.valid = out_vld;

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for sliding_window_maximum: directed and random sample streams.
module tb_top;
  import swm_pkg::*;

  localparam sample_t S_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam sample_t S_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam int CYCLE_LIMIT = 400000;

  typedef enum int {RX_OPEN, RX_HALF, RX_MOSTLY, RX_SPARSE} rx_mode_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  swm_in_if  in_ch ();
  swm_out_if out_ch ();

  sliding_window_maximum uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor state
  logic [CFG_W-1:0] win_reg;
  sample_t          peak_vals [WINDOW_MAX];
  logic [6:0]       peak_ages [WINDOW_MAX];
  int               peak_count;
  int               seq_len;
  sample_t          expected_max[$];

  int fail_count;
  int cycle_count;
  int burst_left;
  bit no_gaps;
  int hold_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int effective_span(input logic [CFG_W-1:0] w);
    if (w == 0) return 1;
    if (w > WINDOW_MAX) return WINDOW_MAX;
    return int'(w);
  endfunction

  function automatic void predict_window_max(input sample_t s, input logic f);
    int w;
    int drop;
    w = effective_span(win_reg);
    if (f) begin
      peak_count = 0;
      seq_len = 0;
    end
    for (int i = 0; i < peak_count; i++) begin
      if (peak_ages[i] <= WINDOW_MAX) peak_ages[i]++;
    end
    drop = 0;
    while (drop < peak_count && peak_ages[drop] >= w) drop++;
    for (int i = 0; i < peak_count - drop; i++) begin
      peak_vals[i] = peak_vals[i + drop];
      peak_ages[i] = peak_ages[i + drop];
    end
    peak_count -= drop;
    while (peak_count > 0 && peak_vals[peak_count - 1] < s) peak_count--;
    if (peak_count < WINDOW_MAX) begin
      peak_vals[peak_count] = s;
      peak_ages[peak_count] = '0;
      peak_count++;
    end
    if (seq_len < WINDOW_MAX) seq_len++;
    if (seq_len >= w) expected_max.insert(expected_max.size(), peak_vals[0]);
  endfunction

  // input monitor and result checker
  always @(posedge clk) begin
    sample_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_max.size() == 0) begin
        $error("window_max: no request expected, got %0d", out_ch.window_max);
        fail_count++;
      end else begin
        want = expected_max[0];
        expected_max.delete(0);
        if (out_ch.window_max !== want) begin
          $error("window_max: expected %0d, got %0d", want, out_ch.window_max);
          fail_count++;
        end
      end
    end
    if (rst_n && in_ch.valid && in_ch.ready) predict_window_max(in_ch.sample, in_ch.first);
  end

  // result receiver
  initial begin
    rx_mode_t mode;
    int span;
    out_ch.ready <= 1'b0;
    mode = RX_OPEN;
    span = 0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_cycles--;
      end else begin
        if (span == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          span = $urandom_range(32, 200);
        end
        span--;
        case (mode)
          RX_OPEN:   out_ch.ready <= 1'b1;
          RX_HALF:   out_ch.ready <= 1'($urandom_range(0, 1));
          RX_MOSTLY: out_ch.ready <= ($urandom_range(0, 9) != 0);
          default:   out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** sliding_window_maximum: FAILED **");
      $finish;
    end
  end

  task automatic send_sample(input sample_t s, input logic f);
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    in_ch.first  <= f;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
    if (burst_left <= 0 && !no_gaps) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 100)
                                                : $urandom_range(1, 24);
    end
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_max.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_window_size(input logic [CFG_W-1:0] w);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(4 * int'(REG_WINDOW_SIZE));
    pwdata  <= APB_DATA_W'(w);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    win_reg = w;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0:       return S_MIN;
      1:       return S_MAX;
      2, 3, 4: return sample_t'($signed($urandom_range(0, 8)) - 4);
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic test_extremes_window_one();
    send_sample(S_MAX, 1'b1);
    send_sample(S_MIN, 1'b0);
    send_sample('0, 1'b0);
    send_sample(-1, 1'b0);
    send_sample(1, 1'b0);
    drain_results();
  endtask

  task automatic test_window_zero();
    write_window_size('0);
    send_sample(5, 1'b1);
    send_sample(-5, 1'b0);
    send_sample(7, 1'b0);
    drain_results();
  endtask

  task automatic test_ties_and_warmup();
    sample_t vals[9] = '{4, 4, 4, 2, 9, 9, 1, 1, 1};
    write_window_size(CFG_W'(3));
    foreach (vals[i]) send_sample(vals[i], i == 0);
    drain_results();
  endtask

  task automatic test_resize_mid_sequence();
    write_window_size(CFG_W'(4));
    send_sample(10, 1'b1);
    send_sample(3, 1'b0);
    send_sample(2, 1'b0);
    send_sample(1, 1'b0);
    drain_results();
    write_window_size(CFG_W'(2));
    send_sample(0, 1'b0);
    send_sample(0, 1'b0);
    drain_results();
    write_window_size(CFG_W'(5));
    send_sample(S_MIN, 1'b0);
    drain_results();
  endtask

  task automatic test_first_clears();
    write_window_size(CFG_W'(2));
    send_sample(100, 1'b1);
    send_sample(50, 1'b0);
    send_sample(-3, 1'b1);
    send_sample(-4, 1'b0);
    drain_results();
  endtask

  task automatic test_random_sequences(input int budget);
    logic [CFG_W-1:0] w;
    int sent;
    int span;
    int len;
    int runs;
    sent = 0;
    while (sent < budget) begin
      case ($urandom_range(0, 19))
        0:       w = '0;
        1:       w = '1;
        2:       w = CFG_W'(WINDOW_MAX);
        3:       w = CFG_W'(WINDOW_MAX - 1);
        4, 5, 6: w = CFG_W'($urandom_range(9, WINDOW_MAX));
        default: w = CFG_W'($urandom_range(1, 8));
      endcase
      drain_results();
      write_window_size(w);
      span = effective_span(w);
      runs = (span > 16) ? 1 : $urandom_range(1, 3);
      repeat (runs) begin
        len = span + $urandom_range(0, (span < 8) ? 12 : span);
        for (int k = 0; k < len; k++) begin
          send_sample(pick_sample(),
                      (k == 0) ? ($urandom_range(0, 5) != 0) : ($urandom_range(0, 60) == 0));
          sent++;
        end
      end
    end
    drain_results();
  endtask

  task automatic test_output_backpressure();
    drain_results();
    write_window_size(CFG_W'(1));
    no_gaps = 1'b1;
    hold_cycles = 200;
    for (int k = 0; k < 60; k++) send_sample(pick_sample(), k == 0);
    no_gaps = 1'b0;
    drain_results();
  endtask

  initial begin
    fail_count  = 0;
    cycle_count = 0;
    burst_left  = 0;
    no_gaps     = 1'b0;
    hold_cycles = 0;
    win_reg     = WIN_RESET;
    peak_count  = 0;
    seq_len     = 0;
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.sample <= '0;
    in_ch.first  <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes_window_one();
    test_window_zero();
    test_ties_and_warmup();
    test_resize_mid_sequence();
    test_first_clears();
    test_random_sequences(700);
    test_output_backpressure();

    drain_results();
    repeat (8) @(posedge clk);
    if (expected_max.size() != 0) begin
      $error("window_max: %0d requests never arrived", expected_max.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("** sliding_window_maximum: PASSED **");
    end else begin
      $display("** sliding_window_maximum: FAILED **");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/swm_pkg.sv
hdl/swm_in_if.sv
hdl/swm_out_if.sv
hdl/swm_cell.sv
hdl/swm_ctrl.sv
hdl/swm_or_tree.sv
hdl/sliding_window_maximum.sv
tb/tb_top.sv
